// ----- design/pal_pkg.sv -----
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, codes and defaults for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic               operation;
		logic [4:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [4:0]         count;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic exec;
	} ctl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;
		logic full;
	} dp_sts_t;

endpackage

// ----- design/positional_array_list.sv -----
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the single result register is the only limit,
// so a new item enters whenever that register is empty or is being taken.
// Every slot shifts in parallel under its own position compare.
// Reset (arst_n low) clears all slots and the fill count and drops rsp_valid.
// ----------------------------------------------------------------------------
// positional_array_list
// Fixed-capacity ordered list with insert and delete by 1-based position.
// ----------------------------------------------------------------------------
module positional_array_list #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pal_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pal_pkg::rsp_t rsp
);
	import pal_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	pal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pal_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp),
		.sts    (sts)
	);

endmodule

// ----- design/pal_ctrl.sv -----
// ----------------------------------------------------------------------------
// pal_ctrl
// Handshake controller: accepts requests and holds one result for the sink.
// ----------------------------------------------------------------------------
module pal_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  pal_pkg::dp_sts_t  sts,
	output pal_pkg::ctl_cmd_t cmd
);
	import pal_pkg::*;

	localparam logic S_EMPTY = 1'b0;
	localparam logic S_HOLD  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	// A new item may enter whenever the result register is free or being drained.
	assign req_stall = (state_q == S_HOLD) && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = (state_q == S_HOLD);
	assign cmd.exec  = accept;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_EMPTY: begin
				if (accept) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (!rsp_stall && !accept) state_d = S_EMPTY;
			end
			default: state_d = S_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted item produced no result");

	a_no_accept_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |-> !accept)
		else $error("item accepted over a stalled result");

	a_list_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.empty && sts.full))
		else $error("list reported empty and full at once");

endmodule

// ----- design/pal_dp.sv -----
// ----------------------------------------------------------------------------
// pal_dp
// Slot row with per-slot shift selection, fill counter and result register.
// ----------------------------------------------------------------------------
module pal_dp #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pal_pkg::ctl_cmd_t cmd,
	input  pal_pkg::req_t     req,
	output pal_pkg::rsp_t     rsp,
	output pal_pkg::dp_sts_t  sts
);
	import pal_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = ((CW > 5) ? CW : 5) + 1;

	logic [31:0]   slots_q [CAPACITY];
	logic [CW-1:0] fill_q;
	logic [CW-1:0] fill_d;
	rsp_t          rsp_q;

	logic [WW-1:0] pos_w;
	logic [WW-1:0] fill_w;
	logic [WW-1:0] idx;
	logic          pos_nz;
	logic          ins_pos_ok;
	logic          del_pos_ok;
	logic          is_full;
	logic          do_ins;
	logic          do_del;
	logic [1:0]    status_d;
	logic [31:0]   picked;
	logic [WW-1:0] fill_nx_w;

	assign pos_w      = WW'(req.position);
	assign fill_w     = WW'(fill_q);
	assign idx        = pos_w - WW'(1);
	assign pos_nz     = (req.position != 5'd0);
	assign ins_pos_ok = pos_nz && (pos_w <= fill_w + WW'(1));
	assign del_pos_ok = pos_nz && (pos_w <= fill_w);
	assign is_full    = (fill_q == CW'(CAPACITY));

	assign do_ins = cmd.exec && (req.operation == OP_INSERT) && ins_pos_ok && !is_full;
	assign do_del = cmd.exec && (req.operation == OP_DELETE) && del_pos_ok;

	always_comb begin
		if (req.operation == OP_INSERT) begin
			if (!ins_pos_ok)   status_d = ST_BADPOS;
			else if (is_full)  status_d = ST_FULL;
			else               status_d = ST_DONE;
		end else begin
			status_d = del_pos_ok ? ST_DONE : ST_BADPOS;
		end
	end

	always_comb begin
		picked = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (WW'(k) == idx) picked = slots_q[k];
		end
	end

	always_comb begin
		fill_d = fill_q;
		if (do_ins)      fill_d = fill_q + CW'(1);
		else if (do_del) fill_d = fill_q - CW'(1);
	end

	assign fill_nx_w = WW'(fill_d);

	// Each slot picks its own word, the word below, the new word or the word above.
	// Slots past the fill point always hold zero, so shifting them keeps them zero.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
		logic [31:0] below;
		logic [31:0] above;
		logic [31:0] slot_d;

		if (k == 0) begin : g_first
			assign below = '0;
		end else begin : g_inner
			assign below = slots_q[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign above = '0;
		end else begin : g_lower
			assign above = slots_q[k+1];
		end

		always_comb begin
			priority if (do_ins && (WW'(k) > idx))  slot_d = below;
			else if (do_ins && (WW'(k) == idx))     slot_d = req.value;
			else if (do_del && (WW'(k) >= idx))     slot_d = above;
			else                                    slot_d = slots_q[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				slots_q[k] <= '0;
			end else begin
				slots_q[k] <= slot_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.status        <= status_d;
			rsp_q.removed_value <= do_del ? picked : '0;
			rsp_q.count         <= fill_nx_w[4:0];
		end
	end

	assign rsp       = rsp_q;
	assign sts.empty = (fill_q == '0);
	assign sts.full  = is_full;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> (fill_q == $past(fill_q) + CW'(1)))
		else $error("insert did not grow the list");

	a_failed_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !do_ins && !do_del) |=> $stable(fill_q))
		else $error("failed request changed the fill count");

endmodule
